[hw/rtl/mrms_pkg.sv]
`default_nettype none

package mrms_pkg;

    localparam int DataW   = 16;
    localparam int CountW  = 25;
    localparam int SumW    = 41;
    localparam int SqW     = 57;
    localparam int ScaleW  = 24;
    localparam int MeanW   = 40;
    localparam int SigmaW  = 39;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 24;

    localparam int MaxVoxelsDefault  = 16777216;
    localparam int QueueDepthDefault = 4;

    localparam logic [ScaleW-1:0] ScaleOne = 24'h010000;

    localparam logic StatusOk    = 1'b0;
    localparam logic StatusEmpty = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RANGE_LOW    = 2'd0,
        CFG_RANGE_HIGH   = 2'd1,
        CFG_RANGE_ENABLE = 2'd2,
        CFG_DATA_SCALE   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [DataW-1:0] data_sample;
        logic signed [DataW-1:0] mask_sample;
        logic                    last_voxel;
    } in_item_t;

    typedef struct packed {
        logic        [CountW-1:0] region_count;
        logic signed [MeanW-1:0]  region_mean;
        logic        [SigmaW-1:0] region_sigma;
        logic                     status;
    } result_t;

    typedef struct packed {
        logic                    pass;
        logic signed [DataW-1:0] data;
        logic                    last;
    } class_item_t;

    typedef struct packed {
        logic [ScaleW-1:0] data_scale;
    } back_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/mrms_front.sv]
`default_nettype none

module mrms_front
    import mrms_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire in_item_t            item,
    output class_item_t              cls,
    output back_cfg_t                bcfg
);

    logic signed [DataW-1:0] range_low_reg;
    logic signed [DataW-1:0] range_high_reg;
    logic                    range_enable_reg;
    logic [ScaleW-1:0]       data_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg    <= '0;
            range_high_reg   <= '0;
            range_enable_reg <= 1'b0;
            data_scale_reg   <= ScaleOne;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RANGE_LOW:    range_low_reg    <= cfg_data[DataW-1:0];
                CFG_RANGE_HIGH:   range_high_reg   <= cfg_data[DataW-1:0];
                CFG_RANGE_ENABLE: range_enable_reg <= cfg_data[0];
                CFG_DATA_SCALE:   data_scale_reg   <= cfg_data[ScaleW-1:0];
            endcase
        end
    end

    logic in_range;

    always_comb
    begin
        in_range = ($signed(item.mask_sample) >= $signed(range_low_reg))
                && ($signed(item.mask_sample) <= $signed(range_high_reg));
        cls.pass = (item.mask_sample != '0) && (!range_enable_reg || in_range);
        cls.data = item.data_sample;
        cls.last = item.last_voxel;
        bcfg.data_scale = (data_scale_reg == '0) ? ScaleOne : data_scale_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/mrms_queue.sv]
`default_nettype none

module mrms_queue
    import mrms_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire class_item_t wr_item,
    output logic             full,
    input  wire logic        pop,
    output class_item_t      rd_item,
    output logic             empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    class_item_t         mem_reg [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == CntW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mrms_back.sv]
`default_nettype none

module mrms_back
    import mrms_pkg::*;
#(
    parameter int MAX_VOXELS = MaxVoxelsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire class_item_t head,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire back_cfg_t   bcfg,
    output result_t          result,
    output logic             empty,
    input  wire logic        pop
);

    localparam int MulAW    = 126;
    localparam int MulBW    = SqW;
    localparam int DivDW    = 48;
    localparam int DevW     = 79;
    localparam int RadW     = 2 * SigmaW;
    localparam int RemW     = SigmaW + 2;
    localparam int DivSteps = MulAW;
    localparam int DivCntW  = $clog2(DivSteps + 1);
    localparam int SqCntW   = $clog2(SigmaW + 1);

    typedef enum logic [10:0] {
        F_IDLE = 11'b00000000001,
        F_MMUL = 11'b00000000010,
        F_MDIV = 11'b00000000100,
        F_SCL  = 11'b00000001000,
        F_NSQ  = 11'b00000010000,
        F_S2   = 11'b00000100000,
        F_DEV  = 11'b00001000000,
        F_NN   = 11'b00010000000,
        F_VDIV = 11'b00100000000,
        F_SQRT = 11'b01000000000,
        F_DONE = 11'b10000000000
    } fin_state_t;

    fin_state_t fin_state_reg, fin_state_next;

    logic        [CountW-1:0] acc_cnt_reg, acc_cnt_next;
    logic signed [SumW-1:0]   acc_sum_reg, acc_sum_next;
    logic        [SqW-1:0]    acc_sq_reg,  acc_sq_next;

    logic [CountW-1:0] n_reg, n_next;
    logic              s_neg_reg, s_neg_next;
    logic [MeanW-1:0]  mag_reg, mag_next;
    logic [SqW-1:0]    sq_reg, sq_next;
    logic [ScaleW-1:0] scale_reg, scale_next;
    logic [MeanW-1:0]  mean_reg, mean_next;
    logic [SigmaW-1:0] sigma_reg, sigma_next;
    logic              status_reg, status_next;
    logic [DivDW-1:0]  scl2_reg, scl2_next;
    logic [DevW-1:0]   nsq_reg, nsq_next;

    logic [MulAW-1:0]  mul_a_reg, mul_a_next;
    logic [MulBW-1:0]  mul_b_reg, mul_b_next;
    logic [MulAW-1:0]  mul_acc_reg, mul_acc_next;

    logic [MulAW-1:0]   div_q_reg, div_q_next;
    logic [DivDW-1:0]   div_r_reg, div_r_next;
    logic [DivDW-1:0]   div_d_reg, div_d_next;
    logic [DivCntW-1:0] div_cnt_reg, div_cnt_next;

    logic [RadW-1:0]   sq_rad_reg, sq_rad_next;
    logic [RemW-1:0]   sq_rem_reg, sq_rem_next;
    logic [SigmaW-1:0] sq_root_reg, sq_root_next;
    logic [SqCntW-1:0] sq_cnt_reg, sq_cnt_next;

    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;

    logic                    take, start, mul_done, res_load;
    logic signed [31:0]      d_sq;
    logic        [CountW-1:0] cnt_upd;
    logic signed [SumW-1:0]  sum_upd;
    logic        [SqW-1:0]   sq_upd;
    logic        [SumW-1:0]  sum_abs;
    logic        [DivDW:0]   div_r2;
    logic                    div_ge;
    logic        [RemW+1:0]  sq_rem2, sq_trial;
    logic                    sq_ge;

    assign q_pop  = !q_empty && (!head.last || fin_state_reg == F_IDLE);
    assign start  = q_pop && head.last;
    assign take   = q_pop && head.pass && (acc_cnt_reg < CountW'(MAX_VOXELS));
    assign empty  = !res_valid_reg;
    assign result = res_reg;
    assign mul_done = (mul_b_reg == '0);

    always_comb
    begin
        d_sq    = $signed(head.data) * $signed(head.data);
        cnt_upd = take ? acc_cnt_reg + CountW'(1) : acc_cnt_reg;
        sum_upd = take ? acc_sum_reg + {{(SumW-DataW){head.data[DataW-1]}}, head.data}
                       : acc_sum_reg;
        sq_upd  = take ? acc_sq_reg + {{(SqW-32){1'b0}}, d_sq} : acc_sq_reg;
        sum_abs = sum_upd[SumW-1] ? -sum_upd : sum_upd;

        if (start)
        begin
            acc_cnt_next = '0;
            acc_sum_next = '0;
            acc_sq_next  = '0;
        end
        else
        begin
            acc_cnt_next = cnt_upd;
            acc_sum_next = sum_upd;
            acc_sq_next  = sq_upd;
        end
    end

    always_comb
    begin
        fin_state_next = fin_state_reg;
        n_next      = n_reg;
        s_neg_next  = s_neg_reg;
        mag_next    = mag_reg;
        sq_next     = sq_reg;
        scale_next  = scale_reg;
        mean_next   = mean_reg;
        sigma_next  = sigma_reg;
        status_next = status_reg;
        scl2_next   = scl2_reg;
        nsq_next    = nsq_reg;
        res_load    = 1'b0;

        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_acc_next = mul_acc_reg;
        if (!mul_done)
        begin
            mul_acc_next = mul_acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);
            mul_a_next   = {mul_a_reg[MulAW-2:0], 1'b0};
            mul_b_next   = {1'b0, mul_b_reg[MulBW-1:1]};
        end

        div_r2     = {div_r_reg, div_q_reg[MulAW-1]};
        div_ge     = (div_r2 >= {1'b0, div_d_reg});
        div_q_next = div_q_reg;
        div_r_next = div_r_reg;
        div_d_next = div_d_reg;
        div_cnt_next = div_cnt_reg;
        if (div_cnt_reg != '0)
        begin
            div_r_next   = div_ge ? DivDW'(div_r2 - {1'b0, div_d_reg}) : div_r2[DivDW-1:0];
            div_q_next   = {div_q_reg[MulAW-2:0], div_ge};
            div_cnt_next = div_cnt_reg - DivCntW'(1);
        end

        sq_rem2  = {sq_rem_reg, sq_rad_reg[RadW-1:RadW-2]};
        sq_trial = {2'b00, sq_root_reg, 2'b01};
        sq_ge    = (sq_rem2 >= sq_trial);
        sq_rad_next  = sq_rad_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        sq_cnt_next  = sq_cnt_reg;
        if (sq_cnt_reg != '0)
        begin
            sq_rem_next  = sq_ge ? RemW'(sq_rem2 - sq_trial) : sq_rem2[RemW-1:0];
            sq_root_next = {sq_root_reg[SigmaW-2:0], sq_ge};
            sq_rad_next  = {sq_rad_reg[RadW-3:0], 2'b00};
            sq_cnt_next  = sq_cnt_reg - SqCntW'(1);
        end

        unique case (fin_state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    n_next      = cnt_upd;
                    s_neg_next  = sum_upd[SumW-1];
                    mag_next    = sum_abs[MeanW-1:0];
                    sq_next     = sq_upd;
                    scale_next  = bcfg.data_scale;
                    mean_next   = '0;
                    sigma_next  = '0;
                    status_next = StatusOk;
                    if (cnt_upd == '0)
                    begin
                        status_next    = StatusEmpty;
                        fin_state_next = F_DONE;
                    end
                    else
                    begin
                        mul_a_next     = MulAW'(sum_abs[MeanW-1:0]);
                        mul_b_next     = MulBW'(bcfg.data_scale);
                        mul_acc_next   = '0;
                        fin_state_next = F_MMUL;
                    end
                end
            end
            F_MMUL:
            begin
                if (mul_done)
                begin
                    div_q_next     = mul_acc_reg;
                    div_r_next     = '0;
                    div_d_next     = DivDW'(n_reg);
                    div_cnt_next   = DivCntW'(DivSteps);
                    fin_state_next = F_MDIV;
                end
            end
            F_MDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    mean_next = s_neg_reg ? -div_q_reg[MeanW-1:0] : div_q_reg[MeanW-1:0];
                    if (n_reg == CountW'(1))
                    begin
                        fin_state_next = F_DONE;
                    end
                    else
                    begin
                        mul_a_next     = MulAW'(scale_reg);
                        mul_b_next     = MulBW'(scale_reg);
                        mul_acc_next   = '0;
                        fin_state_next = F_SCL;
                    end
                end
            end
            F_SCL:
            begin
                if (mul_done)
                begin
                    scl2_next      = mul_acc_reg[DivDW-1:0];
                    mul_a_next     = MulAW'(n_reg);
                    mul_b_next     = sq_reg;
                    mul_acc_next   = '0;
                    fin_state_next = F_NSQ;
                end
            end
            F_NSQ:
            begin
                if (mul_done)
                begin
                    nsq_next       = mul_acc_reg[DevW-1:0];
                    mul_a_next     = MulAW'(mag_reg);
                    mul_b_next     = MulBW'(mag_reg);
                    mul_acc_next   = '0;
                    fin_state_next = F_S2;
                end
            end
            F_S2:
            begin
                if (mul_done)
                begin
                    mul_a_next     = MulAW'(nsq_reg - mul_acc_reg[DevW-1:0]);
                    mul_b_next     = MulBW'(scl2_reg);
                    mul_acc_next   = '0;
                    fin_state_next = F_DEV;
                end
            end
            F_DEV:
            begin
                if (mul_done)
                begin
                    div_q_next     = mul_acc_reg;
                    mul_a_next     = MulAW'(n_reg);
                    mul_b_next     = MulBW'(n_reg - CountW'(1));
                    mul_acc_next   = '0;
                    fin_state_next = F_NN;
                end
            end
            F_NN:
            begin
                if (mul_done)
                begin
                    div_r_next     = '0;
                    div_d_next     = mul_acc_reg[DivDW-1:0];
                    div_cnt_next   = DivCntW'(DivSteps);
                    fin_state_next = F_VDIV;
                end
            end
            F_VDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    if (div_q_reg[MulAW-1:RadW] != '0)
                    begin
                        sigma_next     = '1;
                        fin_state_next = F_DONE;
                    end
                    else
                    begin
                        sq_rad_next    = div_q_reg[RadW-1:0];
                        sq_rem_next    = '0;
                        sq_root_next   = '0;
                        sq_cnt_next    = SqCntW'(SigmaW);
                        fin_state_next = F_SQRT;
                    end
                end
            end
            F_SQRT:
            begin
                if (sq_cnt_reg == '0)
                begin
                    sigma_next     = sq_root_reg;
                    fin_state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_load       = 1'b1;
                    fin_state_next = F_IDLE;
                end
            end
            default:
            begin
                fin_state_next = F_IDLE;
            end
        endcase

        res_next = res_reg;
        if (res_load)
        begin
            res_next.region_count = n_reg;
            res_next.region_mean  = mean_reg;
            res_next.region_sigma = sigma_reg;
            res_next.status       = status_reg;
        end
        res_valid_next = res_load || (res_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_state_reg <= F_IDLE;
            acc_cnt_reg   <= '0;
            acc_sum_reg   <= '0;
            acc_sq_reg    <= '0;
            mul_b_reg     <= '0;
            div_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fin_state_reg <= fin_state_next;
            acc_cnt_reg   <= acc_cnt_next;
            acc_sum_reg   <= acc_sum_next;
            acc_sq_reg    <= acc_sq_next;
            mul_b_reg     <= mul_b_next;
            div_cnt_reg   <= div_cnt_next;
            sq_cnt_reg    <= sq_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        s_neg_reg   <= s_neg_next;
        mag_reg     <= mag_next;
        sq_reg      <= sq_next;
        scale_reg   <= scale_next;
        mean_reg    <= mean_next;
        sigma_reg   <= sigma_next;
        status_reg  <= status_next;
        scl2_reg    <= scl2_next;
        nsq_reg     <= nsq_next;
        mul_a_reg   <= mul_a_next;
        mul_acc_reg <= mul_acc_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
        sq_rad_reg  <= sq_rad_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        res_reg     <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (acc_cnt_reg == '0))
        else $error("accumulators not cleared after last voxel");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(fin_state_reg == F_DONE))
        else $error("result loaded outside finish state");

    assert property (@(posedge clk) disable iff (!rst_n)
        acc_cnt_reg <= CountW'(MAX_VOXELS))
        else $error("voxel count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_state_reg == F_MDIV || fin_state_reg == F_VDIV) |-> (div_r_reg < div_d_reg))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[hw/rtl/masked_region_mean_sigma.sv]
// Voxels: one transaction per cycle into a short queue while it is not full;
// accumulation keeps pace. Result: computed after the last voxel by the shared
// bit-serial multiplier, two 126-step restoring divides and a 39-step root.
// A single voxel skips the variance; an empty volume skips all arithmetic.
// A following volume streams in while the result is computed or waits.
// Reset (rst_n low, asynchronous): accumulators, queue and result cleared,
// range registers zero, range check off, data scale 1.0.
`default_nettype none

module masked_region_mean_sigma
    import mrms_pkg::*;
#(
    parameter int MAX_VOXELS  = MaxVoxelsDefault,
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire in_item_t            item,
    output logic                     empty,
    input  wire logic                pop,
    output result_t                  result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    class_item_t cls, head;
    back_cfg_t   bcfg;
    logic        q_empty, q_pop;

    mrms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cls       (cls),
        .bcfg      (bcfg)
    );

    mrms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (cls),
        .full    (full),
        .pop     (q_pop),
        .rd_item (head),
        .empty   (q_empty)
    );

    mrms_back #(
        .MAX_VOXELS (MAX_VOXELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .bcfg    (bcfg),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire

[tb/region_stats_checker.sv]
`default_nettype none

module region_stats_checker
    import mrms_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                full,
    input  wire in_item_t            item,
    input  wire logic                empty,
    input  wire logic                pop,
    input  wire result_t             result,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output int                       errors,
    output int                       pending,
    output int                       results_seen
);

    localparam longint unsigned VoxelLimit = 64'd16777216;
    localparam logic [63:0] SigmaCap = (64'd1 << SigmaW) - 64'd1;

    logic signed [DataW-1:0] lo_bound;
    logic signed [DataW-1:0] hi_bound;
    logic                    bounds_on;
    logic [ScaleW-1:0]       scale_reg;

    logic [CountW-1:0]       voxel_count;
    logic signed [SumW-1:0]  voxel_sum;
    logic [SqW-1:0]          voxel_sq_sum;

    result_t expected_results[$];

    function automatic result_t region_stats(input logic [CountW-1:0] n,
                                             input logic signed [SumW-1:0] s,
                                             input logic [SqW-1:0] sq,
                                             input logic [ScaleW-1:0] sc);
        result_t r;
        logic [63:0] scale;
        logic [63:0] mag;
        logic [63:0] abs_sum;
        logic [191:0] dev;
        logic [191:0] quot;
        logic [63:0] root;
        logic [63:0] trial;
        r = '0;
        scale = (sc == '0) ? 64'(ScaleOne) : 64'(sc);
        if (n == '0)
        begin
            r.status = StatusEmpty;
            return r;
        end
        r.status = StatusOk;
        r.region_count = n;
        abs_sum = s[SumW-1] ? 64'(-s) : 64'(s);
        mag = (abs_sum * scale) / 64'(n);
        r.region_mean = s[SumW-1] ? MeanW'(-mag) : MeanW'(mag);
        if (n > CountW'(1))
        begin
            dev = 192'(n) * 192'(sq) - 192'(abs_sum) * 192'(abs_sum);
            quot = (dev * 192'(scale) * 192'(scale)) / (192'(n) * (192'(n) - 192'd1));
            root = '0;
            for (int b = 40; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (192'(trial) * 192'(trial) <= quot)
                    root = trial;
            end
            if (root > SigmaCap)
                root = SigmaCap;
            r.region_sigma = SigmaW'(root);
        end
        return r;
    endfunction

    function automatic logic voxel_passes(input logic signed [DataW-1:0] m);
        if (m == '0)
            return 1'b0;
        if (bounds_on)
            return (m >= lo_bound) && (m <= hi_bound);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bound <= '0;
            hi_bound <= '0;
            bounds_on <= 1'b0;
            scale_reg <= ScaleOne;
            voxel_count <= '0;
            voxel_sum <= '0;
            voxel_sq_sum <= '0;
            expected_results.delete();
            errors <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            automatic int err_add = 0;
            automatic int pend = pending;
            automatic logic [CountW-1:0] n = voxel_count;
            automatic logic signed [SumW-1:0] s = voxel_sum;
            automatic logic [SqW-1:0] sq = voxel_sq_sum;
            automatic logic signed [31:0] dsq;
            automatic result_t exp_r;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_RANGE_LOW:    lo_bound <= cfg_data[DataW-1:0];
                    CFG_RANGE_HIGH:   hi_bound <= cfg_data[DataW-1:0];
                    CFG_RANGE_ENABLE: bounds_on <= cfg_data[0];
                    CFG_DATA_SCALE:   scale_reg <= cfg_data[ScaleW-1:0];
                endcase
            end
            if (push && !full)
            begin
                if (voxel_passes(item.mask_sample) && 64'(n) < VoxelLimit)
                begin
                    dsq = item.data_sample * item.data_sample;
                    n = n + CountW'(1);
                    s = s + SumW'(item.data_sample);
                    sq = sq + SqW'(dsq);
                end
                if (item.last_voxel)
                begin
                    expected_results.push_back(region_stats(n, s, sq, scale_reg));
                    pend++;
                    n = '0;
                    s = '0;
                    sq = '0;
                end
                voxel_count <= n;
                voxel_sum <= s;
                voxel_sq_sum <= sq;
            end
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    err_add++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    pend--;
                    if (result.region_count !== exp_r.region_count)
                    begin
                        $error("region_count exp %0d got %0d",
                               exp_r.region_count, result.region_count);
                        err_add++;
                    end
                    if (result.region_mean !== exp_r.region_mean)
                    begin
                        $error("region_mean exp %0d got %0d",
                               exp_r.region_mean, result.region_mean);
                        err_add++;
                    end
                    if (result.region_sigma !== exp_r.region_sigma)
                    begin
                        $error("region_sigma exp %0d got %0d",
                               exp_r.region_sigma, result.region_sigma);
                        err_add++;
                    end
                    if (result.status !== exp_r.status)
                    begin
                        $error("status exp %0d got %0d", exp_r.status, result.status);
                        err_add++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            pending <= pend;
            errors <= errors + err_add;
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    import mrms_pkg::*;

    localparam int CycleLimit = 5000000;
    localparam int Latency    = 700;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    in_item_t            item = '0;
    logic                empty;
    logic                pop = 1'b0;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    int errors;
    int pending;
    int results_seen;
    int voxels_sent = 0;
    int volumes_sent = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_drain = 1'b0;

    always #2 clk = ~clk;

    masked_region_mean_sigma dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    region_stats_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int gap;
        int held;
        gap = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_drain && held < 3000)
            begin
                held++;
                pop <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (Latency) @(posedge clk);
    endtask

    task automatic configure(input logic signed [15:0] lo, input logic signed [15:0] hi,
                             input logic en, input logic [23:0] sc);
        wait_idle();
        write_reg(CFG_RANGE_LOW, 24'(lo));
        write_reg(CFG_RANGE_HIGH, 24'(hi));
        write_reg(CFG_RANGE_ENABLE, 24'(en));
        write_reg(CFG_DATA_SCALE, sc);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_voxel(input logic signed [15:0] d, input logic signed [15:0] m,
                              input logic last);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{data_sample: d, mask_sample: m, last_voxel: last};
        do @(posedge clk); while (full);
        voxels_sent++;
        if (last)
            volumes_sent++;
    endtask

    // mostly masks that pass under the current bounds, some zero, some random
    task automatic send_volume(input int len, input logic signed [15:0] lo,
                               input logic signed [15:0] hi);
        logic signed [15:0] m;
        logic signed [15:0] d;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: m = 16'sd0;
                1, 2: m = 16'($urandom);
                default: m = (lo <= hi) ? 16'($urandom_range(0, hi - lo) + lo) : 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: d = 16'sh7FFF;
                1: d = 16'sh8000;
                default: d = 16'($urandom);
            endcase
            send_voxel(d, m, i == len - 1);
        end
    endtask

    initial
    begin
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [23:0] sc;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single voxel, empty volume, extremes, most-negative mask with range off
        send_voxel(16'sh7FFF, 16'sd1, 1'b1);
        send_voxel(16'sd5, 16'sd0, 1'b1);
        send_voxel(16'sh8000, 16'sh8000, 1'b0);
        send_voxel(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_voxel(16'sh8000, -16'sd1, 1'b0);
        send_voxel(16'sh8000, 16'sd1, 1'b0);
        send_voxel(16'sh8000, 16'sd2, 1'b1);
        configure(-16'sd5, 16'sd5, 1'b1, 24'h0);
        send_voxel(16'sd100, -16'sd5, 1'b0);
        send_voxel(16'sd200, 16'sd5, 1'b0);
        send_voxel(16'sd300, 16'sd6, 1'b0);
        send_voxel(16'sd400, -16'sd6, 1'b0);
        send_voxel(16'sd1, 16'sd0, 1'b1);
        configure(16'sd9, 16'sd3, 1'b1, 24'hFFFFFF);
        send_voxel(16'sd7, 16'sd5, 1'b1);
        configure(16'sh8000, 16'sh7FFF, 1'b1, 24'hFFFFFF);
        send_voxel(16'sh7FFF, 16'sh8000, 1'b0);
        send_voxel(16'sh8000, 16'sh7FFF, 1'b1);
        configure(16'sh8000, 16'sh7FFF, 1'b0, 24'h000001);
        send_voxel(-16'sd3, 16'sd4, 1'b0);
        send_voxel(16'sd2, 16'sd4, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            lo = 16'($urandom);
            hi = 16'($urandom);
            if (lo > hi && $urandom_range(0, 3) != 0)
            begin
                lo = lo ^ hi;
                hi = lo ^ hi;
                lo = lo ^ hi;
            end
            case ($urandom_range(0, 3))
                0: sc = 24'h0;
                1: sc = 24'hFFFFFF;
                2: sc = ScaleOne;
                default: sc = 24'($urandom);
            endcase
            configure(lo, hi, 1'($urandom), sc);
            if (ph == 0)
                hold_drain = 1'b1;
            if (ph == 5)
                calm = 1'b1;
            while (voxels_sent < 22 + (ph + 1) * 300)
                send_volume($urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
                                                       : $urandom_range(4, 40), lo, hi);
        end

        wait_idle();
        $display("covered %0d voxels in %0d volumes, %0d results checked",
                 voxels_sent, volumes_sent, results_seen);
        $display("range bounds on and off, inverted bounds, scale zero/one/max, stalls");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
